/* rtl/kscl_pkg.sv */
// ----------------------------------------------------------------------------
// kscl_pkg
// Shared widths, key codes, result type and key decoding for the keypad
// scanner and code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kscl_pkg;

    localparam int ValueW   = 64;
    localparam int MapW     = 16;
    localparam int RowW     = 2;
    localparam int ColN     = 4;
    localparam int DigitW   = 4;

    localparam logic [ValueW-1:0] PasscodeReset = 64'd64340500038;

    localparam logic [MapW-1:0] KeyClear = 16'h1000;
    localparam logic [MapW-1:0] KeyBack  = 16'h2000;
    localparam logic [MapW-1:0] KeyEnter = 16'h8000;

    typedef struct packed {
        logic [RowW-1:0]   row_to_drive;
        logic              unlocked;
        logic [ValueW-1:0] entered_value;
        logic              key_event;
    } t_result;

    typedef struct packed {
        logic              is_digit;
        logic [DigitW-1:0] digit;
    } t_digit;

    // Map a single-key code onto its decimal digit.
    function automatic t_digit kscl_digit(input logic [MapW-1:0] code);
        t_digit d;
        d.is_digit = 1'b1;
        d.digit    = 4'd0;
        case (code)
            16'h0008: d.digit = 4'd0;
            16'h0004: d.digit = 4'd1;
            16'h0040: d.digit = 4'd2;
            16'h0400: d.digit = 4'd3;
            16'h0002: d.digit = 4'd4;
            16'h0020: d.digit = 4'd5;
            16'h0200: d.digit = 4'd6;
            16'h0001: d.digit = 4'd7;
            16'h0010: d.digit = 4'd8;
            16'h0100: d.digit = 4'd9;
            default:  d.is_digit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/kscl_div10.sv */
// ----------------------------------------------------------------------------
// kscl_div10
// Unsigned divide by ten: reciprocal built from shifts and adds, then one
// correction step on the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module kscl_div10
    import kscl_pkg::*;
(
    input  wire logic [ValueW-1:0] i_dividend,
    output logic      [ValueW-1:0] o_quotient
);

    logic [ValueW-1:0] q0, q1, q2, q3, q4, q5, prod, rem;

    always_comb begin
        // q approximates n * 0.8, then scale down by eight
        q0   = (i_dividend >> 1) + (i_dividend >> 2);
        q1   = q0 + (q0 >> 4);
        q2   = q1 + (q1 >> 8);
        q3   = q2 + (q2 >> 16);
        q4   = q3 + (q3 >> 32);
        q5   = q4 >> 3;
        prod = (q5 << 3) + (q5 << 1);
        rem  = i_dividend - prod;
        // estimate is low by at most one
        o_quotient = (rem > 64'd9) ? q5 + 64'd1 : q5;
    end

endmodule

`default_nettype wire

/* rtl/keypad_scan_code_lock_unit.sv */
// ----------------------------------------------------------------------------
// keypad_scan_code_lock_unit
// 4x4 matrix keypad scanner with decimal entry and passcode lock.
// ----------------------------------------------------------------------------
// One scan tick is taken per clock cycle while o_in_stall is low. The scan,
// key decode and number update are done in the cycle an item is accepted;
// its result goes into the output register, or the skid register if the
// output register is held. This two-entry output buffer lets the block keep
// taking items while a result waits; o_in_stall rises only once both entries
// are full. The passcode write channel is always ready and should be used
// only while no item is in flight. No clearing pass is needed after reset.
`default_nettype none

module keypad_scan_code_lock_unit
    import kscl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ColN-1:0]   i_column_levels,

    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [RowW-1:0]        o_row_to_drive,
    output logic                   o_unlocked,
    output logic [ValueW-1:0]      o_entered_value,
    output logic                   o_key_event,

    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [ValueW-1:0] i_cfg_passcode
);

    logic [ValueW-1:0] r_passcode;
    logic [RowW-1:0]   r_scan_row, n_scan_row;
    logic [MapW-1:0]   r_key_map, n_key_map;
    logic [ValueW-1:0] r_value, n_value;
    logic              r_unlocked, n_unlocked;

    logic              r_out_valid, r_skd_valid;
    t_result           r_out, r_skd;
    t_result           n_res;

    logic              in_acc, out_take, key_event;
    logic [ValueW-1:0] quot;
    t_digit            dec;

    kscl_div10 u_div10 (
        .i_dividend (r_value),
        .o_quotient (quot)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skd_valid;
    assign in_acc      = i_in_valid && !r_skd_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    always_comb begin
        logic [3:0] idx;
        // walk the columns of the driven row in order
        n_key_map = r_key_map;
        for (int i = 0; i < ColN; i++) begin
            idx = {r_scan_row, 2'(i)};
            if (i_column_levels[i]) begin
                n_key_map[idx] = 1'b0;
            end else begin
                n_key_map = MapW'(1) << idx;
            end
        end
        n_scan_row = r_scan_row + RowW'(1);

        key_event  = (n_key_map != '0) && (n_key_map != r_key_map);
        dec        = kscl_digit(n_key_map);
        n_value    = r_value;
        n_unlocked = r_unlocked;
        if (key_event) begin
            if (dec.is_digit) begin
                n_value    = (r_value << 3) + (r_value << 1) + ValueW'(dec.digit);
                n_unlocked = 1'b0;
            end else if (n_key_map == KeyClear) begin
                n_value    = '0;
                n_unlocked = 1'b0;
            end else if (n_key_map == KeyBack) begin
                n_value    = quot;
                n_unlocked = 1'b0;
            end else if (n_key_map == KeyEnter && r_value == r_passcode) begin
                n_unlocked = 1'b1;
            end
        end

        n_res.row_to_drive  = n_scan_row;
        n_res.unlocked      = n_unlocked;
        n_res.entered_value = n_value;
        n_res.key_event     = key_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passcode  <= PasscodeReset;
            r_scan_row  <= '0;
            r_key_map   <= '0;
            r_value     <= '0;
            r_unlocked  <= 1'b0;
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_passcode <= i_cfg_passcode;
            end
            if (in_acc) begin
                r_scan_row <= n_scan_row;
                r_key_map  <= n_key_map;
                r_value    <= n_value;
                r_unlocked <= n_unlocked;
            end
            // drain the skid entry first; park a new item there when blocked
            if (r_skd_valid) begin
                if (out_take) begin
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end
            end else if (in_acc) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_take) begin
                r_out <= r_skd;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skd <= n_res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_row_to_drive  = r_out.row_to_drive;
    assign o_unlocked      = r_out.unlocked;
    assign o_entered_value = r_out.entered_value;
    assign o_key_event     = r_out.key_event;

endmodule

`default_nettype wire

/* rtl/kscl_checker.sv */
// ----------------------------------------------------------------------------
// kscl_checker
// Port-level checks on the keypad scanner and code lock result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kscl_checker
    import kscl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [RowW-1:0]   o_row_to_drive,
    input wire logic              o_unlocked,
    input wire logic [ValueW-1:0] o_entered_value,
    input wire logic              o_key_event
);

    logic              out_acc;
    logic [RowW-1:0]   r_last_row;
    logic [ValueW-1:0] r_last_value;
    logic              r_last_unl;

    assign out_acc = o_out_valid && !i_out_stall;

    // track the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row   <= '0;
            r_last_value <= '0;
            r_last_unl   <= 1'b0;
        end else if (out_acc) begin
            r_last_row   <= o_row_to_drive;
            r_last_value <= o_entered_value;
            r_last_unl   <= o_unlocked;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_entered_value)
            && $stable(o_row_to_drive) && $stable(o_unlocked) && $stable(o_key_event))
        else $error("stalled result changed");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_row_to_drive == r_last_row + RowW'(1))
        else $error("scan row did not advance by one");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_key_event |->
            o_entered_value == r_last_value && o_unlocked == r_last_unl)
        else $error("state changed without a key event");

    a_open_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_unlocked && !r_last_unl |->
            o_key_event && o_entered_value == r_last_value)
        else $error("lock opened without enter");

endmodule

bind keypad_scan_code_lock_unit kscl_checker u_kscl_checker (.*);

`default_nettype wire
